// ===== src/cpt_pkg.sv =====
// cpt_pkg: constants, types and color helper functions of the color palette table
// used by the channel interfaces, the palette core, the top level and the checker
// depends on nothing
package cpt_pkg;

   localparam int DEPTH     = 256;
   localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IDX_W     = 8;
   localparam int COLOR_W   = 8;
   localparam int RGB_W     = 3 * COLOR_W;
   localparam int CNT_W     = $clog2(COLOR_W);
   localparam int MAX_IDX   = (DEPTH - 1 > 255) ? 255 : DEPTH - 1;

   localparam logic [IDX_W-1:0]   MAX_TOP     = IDX_W'(MAX_IDX);
   localparam logic [IDX_W-1:0]   TOP_RESET   = 8'd255;
   localparam logic [COLOR_W-1:0] FULL        = 8'd255;
   localparam logic [COLOR_W-1:0] PASTEL_BASE = 8'd127;
   localparam logic [CNT_W-1:0]   DIV_LAST    = CNT_W'(COLOR_W - 1);
   localparam logic [2:0]         HUE_LAST    = 3'd5;

   typedef enum logic [1:0] {
      FUNC_READ    = 2'd0,
      FUNC_WRITE   = 2'd1,
      FUNC_RAMP    = 2'd2,
      FUNC_OVERLAY = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_BOOT,
      ST_IDLE,
      ST_EXEC,
      ST_DIV,
      ST_FILL,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      SHADE_FULL,
      SHADE_PASTEL,
      SHADE_DARK
   } shade_type;

   typedef logic [2:0] hue_type;

   typedef struct packed {
      func_type           func;
      logic [IDX_W-1:0]   idx;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic [IDX_W-1:0]   first;
      logic [IDX_W-1:0]   last;
   } cmd_type;

   typedef struct packed {
      logic [RGB_W-1:0] rgb;
      logic             status;
   } result_type;

   typedef struct packed {
      logic start;
      logic out_free;
   } core_ctl_type;

   typedef struct packed {
      logic ready;
      logic done;
   } core_sts_type;

   function automatic logic [IDX_W-1:0] clamp_top(input logic [IDX_W-1:0] t);
      return (t > MAX_TOP) ? MAX_TOP : t;
   endfunction

   function automatic logic [RGB_W-1:0] primary_rgb(input hue_type h);
      logic [RGB_W-1:0] c;
      unique case (h)
         3'd0:    c = 24'hFF0000;
         3'd1:    c = 24'h00FF00;
         3'd2:    c = 24'h0000FF;
         3'd3:    c = 24'hFFFF00;
         3'd4:    c = 24'h00FFFF;
         3'd5:    c = 24'hFF00FF;
         default: c = '0;
      endcase
      return c;
   endfunction

   function automatic logic [COLOR_W-1:0] shade_chan(input logic [COLOR_W-1:0] p,
                                                     input shade_type s);
      logic [COLOR_W-1:0] half;
      logic [COLOR_W-1:0] c;
      half = {1'b0, p[COLOR_W-1:1]};
      unique case (s)
         SHADE_FULL:   c = p;
         SHADE_PASTEL: c = half + PASTEL_BASE;
         SHADE_DARK:   c = half;
         default:      c = '0;
      endcase
      return c;
   endfunction

   function automatic logic [RGB_W-1:0] overlay_rgb(input hue_type h, input shade_type s);
      logic [RGB_W-1:0] p;
      p = primary_rgb(h);
      return {shade_chan(p[3*COLOR_W-1:2*COLOR_W], s),
              shade_chan(p[2*COLOR_W-1:COLOR_W], s),
              shade_chan(p[COLOR_W-1:0], s)};
   endfunction

endpackage

// ===== src/cpt_if.sv =====
// cpt_if: valid/ready channel interfaces of the color palette table
// request word, response word and csr write word; depends on cpt_pkg
interface cpt_req_if;
   import cpt_pkg::*;
   logic               valid;
   logic               ready;
   logic [1:0]         func;
   logic [IDX_W-1:0]   index;
   logic [COLOR_W-1:0] red_in;
   logic [COLOR_W-1:0] green_in;
   logic [COLOR_W-1:0] blue_in;
   logic [IDX_W-1:0]   ramp_first;
   logic [IDX_W-1:0]   ramp_last;
   modport source (output valid, func, index, red_in, green_in, blue_in,
                   ramp_first, ramp_last, input ready);
   modport sink   (input valid, func, index, red_in, green_in, blue_in,
                   ramp_first, ramp_last, output ready);
endinterface

interface cpt_rsp_if;
   import cpt_pkg::*;
   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] red_out;
   logic [COLOR_W-1:0] green_out;
   logic [COLOR_W-1:0] blue_out;
   logic               status;
   modport source (output valid, red_out, green_out, blue_out, status, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, status, output ready);
endinterface

interface cpt_csr_if;
   import cpt_pkg::*;
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] top_entry;
   modport source (output valid, top_entry, input ready);
   modport sink   (input valid, top_entry, output ready);
endinterface

// ===== src/color_palette_table_top.sv =====
// color_palette_table_top: top level of the color palette table
// holds the csr register and the response word register; depends on cpt_pkg, cpt_if, cpt_core
//
// usage
// req carries one command word: func 0 reads entry index, 1 writes red_in/green_in/blue_in
// there, 2 fills a gray ramp from ramp_first to ramp_last, 3 fills the overlay colors.
// rsp returns one word per command: the color read (zero for anything but a good read)
// and status, set when index lies beyond the top entry or the ramp range is bad.
// csr writes top_entry, the highest palette entry in use; it is always ready. It must be
// written only while no command is in flight; the user is bound, the block does not enforce it.
// one command at a time: req.ready drops at acceptance and rises again once the response
// word is handed to the output register.
// read and write: the core passes EXEC and DONE, and the response word is then registered.
// overlay fill: one entry per cycle in FILL through the single write port.
// ramp fill: eight divide steps of the shared compare/subtract unit and then one entry
// per cycle.
// reset: top_entry returns to 255 and a ramp fill over the whole palette runs, which
// keeps req.ready low until it ends; csr writes are taken meanwhile.
// a stalled rsp holds its word; the core finishes its command and waits for the output
// register to drain before taking the next word.
module color_palette_table_top (
   input logic       clock,
   input logic       reset,
   cpt_req_if.sink   req,
   cpt_rsp_if.source rsp,
   cpt_csr_if.sink   csr
);
   import cpt_pkg::*;

   logic [IDX_W-1:0] top_entry_ff, top_entry_in;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_word_ff, rsp_word_in;
   core_ctl_type     ctl;
   core_sts_type     sts;
   cmd_type          cmd;
   result_type       result;

   assign csr.ready = 1'b1;

   assign cmd.func  = func_type'(req.func);
   assign cmd.idx   = req.index;
   assign cmd.red   = req.red_in;
   assign cmd.green = req.green_in;
   assign cmd.blue  = req.blue_in;
   assign cmd.first = req.ramp_first;
   assign cmd.last  = req.ramp_last;

   assign req.ready    = sts.ready;
   assign ctl.start    = req.valid && sts.ready;
   assign ctl.out_free = !rsp_valid_ff || rsp.ready;

   cpt_core u_core (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .cmd       (cmd),
      .top_entry (top_entry_ff),
      .sts       (sts),
      .result    (result)
   );

   always_comb begin
      top_entry_in = csr.valid ? csr.top_entry : top_entry_ff;
      rsp_word_in  = sts.done ? result : rsp_word_ff;
      if (sts.done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_entry_ff <= TOP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         top_entry_ff <= top_entry_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.red_out   = rsp_word_ff.rgb[3*COLOR_W-1:2*COLOR_W];
   assign rsp.green_out = rsp_word_ff.rgb[2*COLOR_W-1:COLOR_W];
   assign rsp.blue_out  = rsp_word_ff.rgb[COLOR_W-1:0];
   assign rsp.status    = rsp_word_ff.status;

endmodule

// ===== src/cpt_csub.sv =====
// cpt_csub: shared compare and subtract unit
// serves the restoring divide steps and the ramp error accumulator; depends on cpt_pkg
module cpt_csub (
   input  logic [cpt_pkg::COLOR_W:0]   minuend,
   input  logic [cpt_pkg::COLOR_W-1:0] divisor,
   output logic                        ge,
   output logic [cpt_pkg::COLOR_W-1:0] rest
);
   import cpt_pkg::*;

   logic [COLOR_W:0] diff;

   assign diff = minuend - {1'b0, divisor};
   assign ge   = (minuend >= {1'b0, divisor});
   assign rest = ge ? diff[COLOR_W-1:0] : minuend[COLOR_W-1:0];

endmodule

// ===== src/cpt_core.sv =====
// cpt_core: palette memory, command sequencer and fill walker
// uses cpt_csub for division and ramp stepping; depends on cpt_pkg
module cpt_core (
   input  logic                      clock,
   input  logic                      reset,
   input  cpt_pkg::core_ctl_type     ctl,
   input  cpt_pkg::cmd_type          cmd,
   input  logic [cpt_pkg::IDX_W-1:0] top_entry,
   output cpt_pkg::core_sts_type     sts,
   output cpt_pkg::result_type       result
);
   import cpt_pkg::*;

   state_type          state_ff, state_in;
   logic               boot_ff, boot_in;
   cmd_type            cmd_ff, cmd_in;
   logic [IDX_W-1:0]   top_ff, top_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [COLOR_W-1:0] acc_q_ff, acc_q_in;
   logic [COLOR_W-1:0] acc_r_ff, acc_r_in;
   logic [COLOR_W-1:0] step_q_ff, step_q_in;
   logic [COLOR_W-1:0] step_r_ff, step_r_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   hue_type            hue_ff, hue_in;
   shade_type          shade_ff, shade_in;
   logic               status_ff, status_in;
   logic               rd_ok_ff, rd_ok_in;
   logic [RGB_W-1:0]   rd_data_ff;

   logic [RGB_W-1:0]   palette_mem [DEPTH];

   logic               mem_we;
   logic [IDX_W-1:0]   mem_addr;
   logic [RGB_W-1:0]   mem_wdata;

   logic [COLOR_W-1:0] span;
   logic               range_err;
   logic               idx_err;
   logic               fill_end;
   logic               is_ovl;
   logic [COLOR_W:0]   r_sum;
   logic [COLOR_W:0]   q_sum;
   logic [COLOR_W:0]   minuend;
   logic               ge;
   logic [COLOR_W-1:0] rest;
   logic [RGB_W-1:0]   fill_rgb;
   logic               in_ramp;

   assign span      = cmd_ff.last - cmd_ff.first;
   assign range_err = (cmd_ff.first > cmd_ff.last) || (cmd_ff.last > top_ff);
   assign idx_err   = (cmd_ff.idx > top_ff);
   assign fill_end  = (idx_ff == top_ff);
   assign is_ovl    = (cmd_ff.func == FUNC_OVERLAY);
   assign in_ramp   = (idx_ff >= cmd_ff.first) && (idx_ff < cmd_ff.last);
   assign r_sum     = {1'b0, acc_r_ff} + {1'b0, step_r_ff};
   assign q_sum     = {1'b0, acc_q_ff} + {1'b0, step_q_ff} + {{COLOR_W{1'b0}}, ge};
   assign minuend   = (state_ff == ST_DIV) ? {acc_r_ff, 1'b1} : r_sum;

   cpt_csub u_csub (
      .minuend (minuend),
      .divisor (span),
      .ge      (ge),
      .rest    (rest)
   );

   always_comb begin
      if (is_ovl) begin
         fill_rgb = (idx_ff == '0) ? '0 : overlay_rgb(hue_ff, shade_ff);
      end else begin
         priority if (idx_ff < cmd_ff.first) begin
            fill_rgb = {3{FULL}};
         end else if (!(idx_ff < cmd_ff.last)) begin
            fill_rgb = '0;
         end else begin
            fill_rgb = {3{FULL - acc_q_ff}};
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_BOOT: state_in = ST_EXEC;
         ST_IDLE: begin
            if (ctl.start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            unique case (cmd_ff.func)
               FUNC_READ, FUNC_WRITE: state_in = ST_DONE;
               FUNC_RAMP:             state_in = range_err ? ST_DONE : ST_DIV;
               FUNC_OVERLAY:          state_in = ST_FILL;
               default:               state_in = ST_DONE;
            endcase
         end
         ST_DIV: begin
            if (cnt_ff == DIV_LAST) state_in = ST_FILL;
         end
         ST_FILL: begin
            if (fill_end) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (boot_ff || ctl.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      sts.ready     = (state_ff == ST_IDLE);
      sts.done      = (state_ff == ST_DONE) && !boot_ff && ctl.out_free;
      result.rgb    = rd_ok_ff ? rd_data_ff : '0;
      result.status = status_ff;
      mem_we        = 1'b0;
      mem_addr      = idx_ff;
      mem_wdata     = fill_rgb;
      unique case (state_ff)
         ST_EXEC: begin
            if ((cmd_ff.func == FUNC_WRITE) && !idx_err) begin
               mem_we    = 1'b1;
               mem_addr  = cmd_ff.idx;
               mem_wdata = {cmd_ff.red, cmd_ff.green, cmd_ff.blue};
            end
         end
         ST_FILL: mem_we = 1'b1;
         default: mem_we = 1'b0;
      endcase
   end

   // datapath next values
   always_comb begin
      boot_in   = boot_ff;
      cmd_in    = cmd_ff;
      top_in    = top_ff;
      idx_in    = idx_ff;
      acc_q_in  = acc_q_ff;
      acc_r_in  = acc_r_ff;
      step_q_in = step_q_ff;
      step_r_in = step_r_ff;
      cnt_in    = cnt_ff;
      hue_in    = hue_ff;
      shade_in  = shade_ff;
      status_in = status_ff;
      rd_ok_in  = rd_ok_ff;
      unique case (state_ff)
         ST_BOOT: begin
            cmd_in       = '0;
            cmd_in.func  = FUNC_RAMP;
            cmd_in.first = '0;
            cmd_in.last  = clamp_top(TOP_RESET);
            top_in       = clamp_top(TOP_RESET);
         end
         ST_IDLE: begin
            if (ctl.start) begin
               cmd_in = cmd;
               top_in = clamp_top(top_entry);
            end
         end
         ST_EXEC: begin
            status_in = 1'b0;
            rd_ok_in  = 1'b0;
            idx_in    = '0;
            hue_in    = '0;
            shade_in  = SHADE_FULL;
            acc_q_in  = '0;
            acc_r_in  = '0;
            step_q_in = '0;
            cnt_in    = '0;
            unique case (cmd_ff.func)
               FUNC_READ: begin
                  status_in = idx_err;
                  rd_ok_in  = !idx_err;
               end
               FUNC_WRITE:   status_in = idx_err;
               FUNC_RAMP:    status_in = range_err;
               FUNC_OVERLAY: status_in = 1'b0;
               default:      status_in = 1'b0;
            endcase
         end
         ST_DIV: begin
            acc_r_in  = rest;
            step_q_in = {step_q_ff[COLOR_W-2:0], ge};
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               step_r_in = rest;
               acc_r_in  = '0;
               acc_q_in  = '0;
            end
         end
         ST_FILL: begin
            idx_in = idx_ff + 1'b1;
            if (is_ovl) begin
               if (idx_ff != '0) begin
                  if (hue_ff == HUE_LAST) begin
                     hue_in = '0;
                     unique case (shade_ff)
                        SHADE_FULL:   shade_in = SHADE_PASTEL;
                        SHADE_PASTEL: shade_in = SHADE_DARK;
                        SHADE_DARK:   shade_in = SHADE_FULL;
                        default:      shade_in = SHADE_FULL;
                     endcase
                  end else begin
                     hue_in = hue_ff + 1'b1;
                  end
               end
            end else if (in_ramp) begin
               acc_r_in = rest;
               acc_q_in = q_sum[COLOR_W-1:0];
            end
         end
         ST_DONE: begin
            boot_in = 1'b0;
         end
         default: boot_in = boot_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_BOOT;
         boot_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         boot_ff  <= boot_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      top_ff    <= top_in;
      idx_ff    <= idx_in;
      acc_q_ff  <= acc_q_in;
      acc_r_ff  <= acc_r_in;
      step_q_ff <= step_q_in;
      step_r_ff <= step_r_in;
      cnt_ff    <= cnt_in;
      hue_ff    <= hue_in;
      shade_ff  <= shade_in;
      status_ff <= status_in;
      rd_ok_ff  <= rd_ok_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         palette_mem[ADDR_W'(mem_addr)] <= mem_wdata;
      end
      rd_data_ff <= palette_mem[ADDR_W'(cmd_ff.idx)];
   end

endmodule

// ===== src/cpt_check.sv =====
// cpt_check: port-level checks of the color palette table and their bind
// sees only the top level ports; depends on cpt_pkg and color_palette_table_top
module cpt_check (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [cpt_pkg::COLOR_W-1:0] red,
   input logic [cpt_pkg::COLOR_W-1:0] green,
   input logic [cpt_pkg::COLOR_W-1:0] blue,
   input logic                        status
);
   import cpt_pkg::*;

   logic [RGB_W:0] rsp_word;

   assign rsp_word = {red, green, blue, status};

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("stalled response word changed");

   a_boot_busy: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("ready during boot fill");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("word taken while a command is in flight");

   a_err_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status |-> (red == '0) && (green == '0) && (blue == '0))
      else $error("error response carries a color");

endmodule

bind color_palette_table_top cpt_check u_cpt_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .red       (rsp.red_out),
   .green     (rsp.green_out),
   .blue      (rsp.blue_out),
   .status    (rsp.status)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking testbench of color_palette_table_top, directed table then random words
// keeps its own copy of the palette and top entry; depends on cpt_pkg, cpt_if and the rtl
module tb;
   import cpt_pkg::*;

   localparam int          LIMIT      = 2_000_000;
   localparam int          SETTLE     = 20;
   localparam int          HOLD_LEN   = 400;
   localparam int          PHASES     = 6;
   localparam int          PHASE_LEN  = 150;
   localparam int          PLAN_LEN   = 28;
   localparam logic        STAT_OK    = 1'b0;
   localparam logic        STAT_ERR   = 1'b1;
   localparam int          TOP_RANDOM = -1;
   localparam int          PHASE_TOP [PHASES] = '{0, 200, 7, 255, TOP_RANDOM, 1};
   localparam logic [23:0] HUE_RGB [6] = '{24'hFF0000, 24'h00FF00, 24'h0000FF,
                                           24'hFFFF00, 24'h00FFFF, 24'hFF00FF};

   typedef struct {
      bit          set_top;
      func_type    func;
      logic [7:0]  idx;
      logic [23:0] rgb;
      logic [7:0]  first;
      logic [7:0]  last;
      bit          typed;
      logic [23:0] want_rgb;
      logic        want_status;
   } plan_row_type;

   // set_top rows carry the new top entry in idx
   plan_row_type plan [PLAN_LEN] = '{
      '{0, FUNC_READ,    8'd0,   24'h0,      8'd0,   8'd0,   1, 24'hFFFFFF, STAT_OK},
      '{0, FUNC_READ,    8'd255, 24'h0,      8'd0,   8'd0,   1, 24'h000000, STAT_OK},
      '{0, FUNC_READ,    8'd128, 24'h0,      8'd0,   8'd0,   1, 24'h7F7F7F, STAT_OK},
      '{0, FUNC_WRITE,   8'd255, 24'hFF00AA, 8'd0,   8'd0,   1, 24'h000000, STAT_OK},
      '{0, FUNC_READ,    8'd255, 24'h0,      8'd0,   8'd0,   1, 24'hFF00AA, STAT_OK},
      '{0, FUNC_RAMP,    8'd0,   24'h0,      8'd0,   8'd255, 1, 24'h000000, STAT_OK},
      '{0, FUNC_READ,    8'd1,   24'h0,      8'd0,   8'd0,   0, 24'h000000, STAT_OK},
      '{0, FUNC_RAMP,    8'd0,   24'h0,      8'd10,  8'd10,  1, 24'h000000, STAT_OK},
      '{0, FUNC_READ,    8'd9,   24'h0,      8'd0,   8'd0,   1, 24'hFFFFFF, STAT_OK},
      '{0, FUNC_READ,    8'd10,  24'h0,      8'd0,   8'd0,   1, 24'h000000, STAT_OK},
      '{0, FUNC_RAMP,    8'd0,   24'h0,      8'd200, 8'd100, 1, 24'h000000, STAT_ERR},
      '{0, FUNC_RAMP,    8'd0,   24'h0,      8'd255, 8'd255, 1, 24'h000000, STAT_OK},
      '{0, FUNC_READ,    8'd254, 24'h0,      8'd0,   8'd0,   1, 24'hFFFFFF, STAT_OK},
      '{0, FUNC_OVERLAY, 8'd0,   24'h0,      8'd0,   8'd0,   1, 24'h000000, STAT_OK},
      '{0, FUNC_READ,    8'd1,   24'h0,      8'd0,   8'd0,   0, 24'h000000, STAT_OK},
      '{0, FUNC_READ,    8'd7,   24'h0,      8'd0,   8'd0,   0, 24'h000000, STAT_OK},
      '{0, FUNC_READ,    8'd13,  24'h0,      8'd0,   8'd0,   0, 24'h000000, STAT_OK},
      '{0, FUNC_READ,    8'd255, 24'h0,      8'd0,   8'd0,   0, 24'h000000, STAT_OK},
      '{1, FUNC_READ,    8'd0,   24'h0,      8'd0,   8'd0,   0, 24'h000000, STAT_OK},
      '{0, FUNC_READ,    8'd0,   24'h0,      8'd0,   8'd0,   0, 24'h000000, STAT_OK},
      '{0, FUNC_READ,    8'd1,   24'h0,      8'd0,   8'd0,   1, 24'h000000, STAT_ERR},
      '{0, FUNC_WRITE,   8'd255, 24'h123456, 8'd0,   8'd0,   1, 24'h000000, STAT_ERR},
      '{0, FUNC_RAMP,    8'd0,   24'h0,      8'd0,   8'd1,   1, 24'h000000, STAT_ERR},
      '{0, FUNC_RAMP,    8'd0,   24'h0,      8'd0,   8'd0,   1, 24'h000000, STAT_OK},
      '{0, FUNC_OVERLAY, 8'd0,   24'h0,      8'd0,   8'd0,   1, 24'h000000, STAT_OK},
      '{1, FUNC_READ,    8'd255, 24'h0,      8'd0,   8'd0,   0, 24'h000000, STAT_OK},
      '{0, FUNC_READ,    8'd255, 24'h0,      8'd0,   8'd0,   0, 24'h000000, STAT_OK},
      '{0, FUNC_READ,    8'd2,   24'h0,      8'd0,   8'd0,   0, 24'h000000, STAT_OK}
   };

   logic        clock;
   logic        reset;
   logic [23:0] palette_copy [DEPTH];
   logic [7:0]  top_copy;
   result_type  color_words [$];
   int          mismatches;
   int          cycles;
   int          send_idle;
   int          recv_idle;
   bit          hold_request;
   int          hold_left;

   cpt_req_if req_ch ();
   cpt_rsp_if rsp_ch ();
   cpt_csr_if csr_ch ();

   color_palette_table_top i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   function automatic int top_now();
      return (top_copy > DEPTH - 1) ? DEPTH - 1 : int'(top_copy);
   endfunction

   function automatic bit gray_ramp(int first, int last);
      int          t;
      logic [7:0]  v;
      t = top_now();
      if (first > last || last > t) return 1'b0;
      for (int i = 0; i < first; i++) palette_copy[i] = 24'hFFFFFF;
      for (int i = last; i <= t; i++) palette_copy[i] = 24'h000000;
      for (int i = first; i < last; i++) begin
         v = 8'(255 - ((i - first) * 255) / (last - first));
         palette_copy[i] = {v, v, v};
      end
      return 1'b1;
   endfunction

   function automatic result_type palette_step(cmd_type c);
      result_type  r;
      int          t;
      int          k;
      logic [23:0] hue;
      logic [7:0]  p;
      logic [23:0] col;
      r = '0;
      t = top_now();
      case (c.func)
         FUNC_READ: begin
            if (c.idx > t) r.status = STAT_ERR;
            else r.rgb = palette_copy[c.idx];
         end
         FUNC_WRITE: begin
            if (c.idx > t) r.status = STAT_ERR;
            else palette_copy[c.idx] = {c.red, c.green, c.blue};
         end
         FUNC_RAMP: begin
            r.status = gray_ramp(c.first, c.last) ? STAT_OK : STAT_ERR;
         end
         default: begin
            palette_copy[0] = 24'h000000;
            for (int i = 1; i <= t; i++) begin
               k = i - 1;
               hue = HUE_RGB[k % 6];
               for (int j = 0; j < 3; j++) begin
                  p = hue[8*j +: 8];
                  case (shade_type'((k / 6) % 3))
                     SHADE_FULL:   col[8*j +: 8] = p;
                     SHADE_PASTEL: col[8*j +: 8] = p / 2 + 8'd127;
                     default:      col[8*j +: 8] = p / 2;
                  endcase
               end
               palette_copy[i] = col;
            end
         end
      endcase
      return r;
   endfunction

   function automatic cmd_type random_cmd();
      cmd_type c;
      int      t;
      int      pick;
      t = top_now();
      c.idx   = 8'($urandom_range(255));
      c.red   = 8'($urandom_range(255));
      c.green = 8'($urandom_range(255));
      c.blue  = 8'($urandom_range(255));
      c.first = 8'($urandom_range(255));
      c.last  = 8'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 40) c.func = FUNC_READ;
      else if (pick < 75) c.func = FUNC_WRITE;
      else if (pick < 90) c.func = FUNC_RAMP;
      else c.func = FUNC_OVERLAY;
      if ($urandom_range(99) < 80) c.idx = 8'($urandom_range(t));
      if ($urandom_range(99) < 70) begin
         c.last  = 8'($urandom_range(t));
         c.first = 8'($urandom_range(c.last));
      end
      return c;
   endfunction

   task automatic flag_error(string field, logic [23:0] got, logic [23:0] want);
      mismatches++;
      $display("tb: mismatch on %s: got %h, wanted %h", field, got, want);
   endtask

   task automatic check_word();
      result_type want;
      if (color_words.size() == 0) begin
         flag_error("word with none pending", {rsp_ch.red_out, rsp_ch.green_out,
                    rsp_ch.blue_out}, 24'h0);
         return;
      end
      want = color_words.pop_front();
      if (rsp_ch.red_out !== want.rgb[23:16])
         flag_error("red_out", rsp_ch.red_out, want.rgb[23:16]);
      if (rsp_ch.green_out !== want.rgb[15:8])
         flag_error("green_out", rsp_ch.green_out, want.rgb[15:8]);
      if (rsp_ch.blue_out !== want.rgb[7:0])
         flag_error("blue_out", rsp_ch.blue_out, want.rgb[7:0]);
      if (rsp_ch.status !== want.status)
         flag_error("status", rsp_ch.status, want.status);
   endtask

   task automatic send_cmd(cmd_type c, bit typed, result_type want);
      result_type predicted;
      while ($urandom_range(99) < send_idle) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.func       <= c.func;
      req_ch.index      <= c.idx;
      req_ch.red_in     <= c.red;
      req_ch.green_in   <= c.green;
      req_ch.blue_in    <= c.blue;
      req_ch.ramp_first <= c.first;
      req_ch.ramp_last  <= c.last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predicted = palette_step(c);
      color_words.push_back(typed ? want : predicted);
   endtask

   // block idle: nothing pending and the core ready again
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (color_words.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic write_top(logic [7:0] value);
      csr_ch.valid     <= 1'b1;
      csr_ch.top_entry <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      top_copy = value;
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > LIMIT) begin
            $display("tb: done, errors");
            $finish;
         end
      end
   end

   // response side: checks each word taken, with random stalls and one long hold
   initial begin
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) check_word();
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_LEN;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   initial begin
      cmd_type    c;
      result_type want;
      int         t;
      mismatches   = 0;
      send_idle    = 0;
      recv_idle    = 0;
      hold_request = 1'b0;
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.func       <= FUNC_READ;
      req_ch.index      <= '0;
      req_ch.red_in     <= '0;
      req_ch.green_in   <= '0;
      req_ch.blue_in    <= '0;
      req_ch.ramp_first <= '0;
      req_ch.ramp_last  <= '0;
      rsp_ch.ready      <= 1'b0;
      csr_ch.valid      <= 1'b0;
      csr_ch.top_entry  <= '0;

      top_copy = TOP_RESET;
      foreach (palette_copy[i]) palette_copy[i] = 24'h000000;
      void'(gray_ramp(0, top_now()));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int n = 0; n < PLAN_LEN; n++) begin
         if (plan[n].set_top) begin
            settle();
            write_top(plan[n].idx);
         end else begin
            c.func  = plan[n].func;
            c.idx   = plan[n].idx;
            {c.red, c.green, c.blue} = plan[n].rgb;
            c.first = plan[n].first;
            c.last  = plan[n].last;
            want.rgb    = plan[n].want_rgb;
            want.status = plan[n].want_status;
            send_cmd(c, plan[n].typed, want);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         t = PHASE_TOP[ph];
         write_top((t == TOP_RANDOM) ? 8'($urandom_range(255)) : 8'(t));
         send_idle = (ph < 2) ? 15 : (ph < 4) ? 60 : 0;
         recv_idle = (ph < 2) ? 60 : (ph < 4) ? 15 : 0;
         if (ph == 2) hold_request = 1'b1;
         repeat (PHASE_LEN) begin
            c = random_cmd();
            send_cmd(c, 1'b0, '0);
         end
      end

      settle();
      if (mismatches == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule

// ===== sim.f =====
src/cpt_pkg.sv
src/cpt_if.sv
src/cpt_csub.sv
src/cpt_core.sv
src/color_palette_table_top.sv
src/cpt_check.sv
test/tb.sv
